FILE: src/rcs_pkg.sv
package rcs_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RANK_W  = 6;

  // Element traveling down the chain with its running count of smaller stored values
  typedef struct packed {
    logic                      vld;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         below;
  } token_t;

  // Occupancy and rank of one cell, shifted toward cell 0 while results drain
  typedef struct packed {
    logic              occ;
    logic [RANK_W-1:0] cnt;
  } slot_t;

endpackage

FILE: src/rcs_cell.sv
module rcs_cell
  import rcs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  token_t tok_in,
  output token_t tok_out,
  input  logic   shift,
  input  slot_t  slot_in,
  output slot_t  slot_out,
  output logic   busy
);

  token_t                    tok_r;
  logic                      occ_r;
  logic signed [VALUE_W-1:0] val_r;
  logic [RANK_W-1:0]         cnt_r;
  logic                      stored_lt;
  logic                      stored_gt;

  // Compare the passing element against the stored one
  assign stored_lt = val_r < tok_r.value;
  assign stored_gt = val_r > tok_r.value;

  // Pass the element on when this cell is taken, counting a smaller stored value
  always_comb begin
    tok_out.vld   = tok_r.vld & occ_r;
    tok_out.value = tok_r.value;
    tok_out.below = tok_r.below + RANK_W'(occ_r & stored_lt);
  end

  assign slot_out.occ = occ_r;
  assign slot_out.cnt = cnt_r;
  assign busy         = tok_r.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      occ_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      tok_r <= tok_in;
      if (shift) begin
        // Advance results one cell toward the output
        occ_r <= slot_in.occ;
        cnt_r <= slot_in.cnt;
      end else if (tok_r.vld) begin
        if (occ_r) begin
          // A smaller newcomer raises this rank
          if (stored_gt) begin
            cnt_r <= cnt_r + RANK_W'(1);
          end
        end else begin
          // Settle the element in the first free cell
          occ_r <= 1'b1;
          val_r <= tok_r.value;
          cnt_r <= tok_r.below;
        end
      end
    end
  end

endmodule

FILE: src/rank_count_smaller_unit.sv
// Loading: one element per cycle while in_ready is high; an element walks the cell chain
// one cell per cycle and settles in cell k, where k is its arrival position.
// After the last element is accepted, input stalls while the chain settles and the results
// drain; N stored elements give N results, leaving one per cycle from cell 0 while out_ready is high.
// Synchronous active-low reset empties all cells; the block also empties itself after a set.
module rank_count_smaller_unit
  import rcs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [RANK_W-1:0]         out_rank,
  output logic                      out_final_res,
  output logic                      out_overflow
);

  localparam int unsigned FILL_W = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } state_t;

  state_t              state_r;
  logic [FILL_W-1:0]   fill_r;
  logic                dropped_r;
  logic                in_acc;
  logic                out_acc;
  logic                has_room;
  logic                shift;
  logic                chain_busy;
  logic [MAX_ELEMENTS-1:0] busy;
  token_t              tok_chain [0:MAX_ELEMENTS];
  slot_t               slot_chain [0:MAX_ELEMENTS];

  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid & in_ready;
  assign has_room = fill_r < FILL_W'(MAX_ELEMENTS);

  // Inject an element into the head of the chain when a cell is still free
  always_comb begin
    tok_chain[0].vld   = in_acc & has_room;
    tok_chain[0].value = in_value;
    tok_chain[0].below = '0;
  end

  assign slot_chain[MAX_ELEMENTS] = '0;

  genvar k;
  generate
    for (k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
      rcs_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_in   (tok_chain[k]),
        .tok_out  (tok_chain[k+1]),
        .shift    (shift),
        .slot_in  (slot_chain[k+1]),
        .slot_out (slot_chain[k]),
        .busy     (busy[k])
      );
    end
  endgenerate

  // An element still walking the chain
  assign chain_busy = (|busy) | tok_chain[MAX_ELEMENTS].vld;

  // Results come straight from cell 0
  assign out_valid     = (state_r == ST_DRAIN) & slot_chain[0].occ;
  assign out_rank      = slot_chain[0].cnt;
  assign out_final_res = slot_chain[0].occ & ~slot_chain[1].occ;
  assign out_overflow  = dropped_r;
  assign out_acc       = out_valid & out_ready;
  assign shift         = out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      fill_r    <= '0;
      dropped_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            // Count stored elements, flag the ones beyond capacity
            if (has_room) begin
              fill_r <= fill_r + FILL_W'(1);
            end else begin
              dropped_r <= 1'b1;
            end
            if (in_last) begin
              state_r <= ST_SETTLE;
            end
          end
        end
        ST_SETTLE: begin
          if (!chain_busy) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // Drop back to loading once the final result leaves
          if (out_acc && out_final_res) begin
            state_r   <= ST_LOAD;
            fill_r    <= '0;
            dropped_r <= 1'b0;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
